// ===== hw/rtl/cgpq_pkg.sv =====
// Shared types, widths and depths of the credit-gated present queue.
`default_nettype none

package cgpq_pkg;

  // Field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned AMT_W    = 8;
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned CREDIT_W = 16;

  // Packed stream words, filled up to whole bytes
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - TAG_W - TIME_W;

  // Queue depths and derived pointer and fill widths
  localparam int unsigned PENDING_DEPTH  = 16;
  localparam int unsigned INFLIGHT_DEPTH = 16;
  localparam int unsigned PEND_PTR_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned PEND_FILL_W = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned INFL_PTR_W  = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
  localparam int unsigned INFL_FILL_W = $clog2(INFLIGHT_DEPTH + 1);

  // Result limits per input word
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  // Width that holds both an amount and an in-flight fill
  localparam int unsigned CMP_W = (AMT_W + 1 > INFL_FILL_W) ? AMT_W + 1 : INFL_FILL_W;

  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRESENT = 2'd0,
    ACT_GRANT   = 2'd1,
    ACT_DONE    = 2'd2
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ISSUED    = 2'd0,
    KIND_COMPLETED = 2'd1,
    KIND_DROP      = 2'd2,
    KIND_UNDER     = 2'd3
  } kind_e;

endpackage

`default_nettype wire

// ===== hw/rtl/credit_gated_present_queue.sv =====
// Top level of the credit-gated present queue: sequencer, counters and output register.
//
// Input stream (s_axis_*): one word per event. tuser carries the action (present
// request, credit grant, frame presented); tdata carries request_tag, amount and
// present_time. Output stream (m_axis_*): one word per result; tuser carries the
// kind, tdata the tag and time_out, tlast marks the final result of an event.
// Events that cause no result (a queued request, a grant that drains nothing,
// a completion of zero, an unused action) produce no output word.
// Sequencing: a present request is handled in the idle state and its result, if any,
// is registered and visible the next cycle. A grant or completion runs a sequencer over
// the tag memories: each result takes a read state (S_DRAIN_CHK or S_POP_RD), then an
// emit state. A completion that ends in an underflow word goes through S_UNDER after
// its last read state; a grant or completion that causes no result passes through one
// read state and returns to idle.
// The registered read port of each tag memory is why each emit state follows a read state.
// A new input word is taken only while the sequencer is idle and the output
// register is free or being emptied. When the receiver stalls, the output
// register holds its word and the sequencer waits; nothing is lost.
// Reset clears credits, queue pointers and fill counts; tag memories are not cleared.
`default_nettype none

module credit_gated_present_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // request_tag [7:0], amount [15:8], present_time [78:16], zero pad [79]
  input  logic [cgpq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action [1:0]
  input  logic [cgpq_pkg::ACT_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tag [7:0], time_out [70:8], zero pad [71]
  output logic [cgpq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // kind [1:0]
  output logic [cgpq_pkg::KIND_W-1:0]        m_axis_tuser,
  output logic                               m_axis_tlast
);

  import cgpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAIN_CHK,
    S_DRAIN_EMIT,
    S_POP_RD,
    S_POP_EMIT,
    S_UNDER
  } state_e;

  state_e                 state_q;
  logic [CREDIT_W-1:0]    credit_q;
  logic [PEND_PTR_W-1:0]  pend_head_q, pend_tail_q;
  logic [PEND_FILL_W-1:0] pend_fill_q;
  logic [INFL_PTR_W-1:0]  infl_head_q, infl_tail_q;
  logic [INFL_FILL_W-1:0] infl_fill_q;
  logic [RES_CNT_W-1:0]   res_cnt_q;
  logic [RES_CNT_W-1:0]   pops_q;
  logic                   under_q;
  logic [TIME_W-1:0]      time_q;

  logic                   m_valid_q;
  kind_e                  m_kind_q;
  logic [TAG_W-1:0]       m_tag_q;
  logic [TIME_W-1:0]      m_time_q;
  logic                   m_last_q;

  logic                   in_fire, out_free, m_load;
  action_e                in_action;
  logic [TAG_W-1:0]       in_tag;
  logic [AMT_W-1:0]       in_amount;
  logic [TIME_W-1:0]      in_time;
  logic                   can_issue, direct_issue, pend_full;
  logic [CREDIT_W:0]      credit_sum;
  logic [CREDIT_W-1:0]    credit_sat;
  logic                   drain_go, drain_more;
  logic [CMP_W-1:0]       amt_x, fill_x, pop_min, pop_cap;
  logic                   pop_under;
  logic [RES_CNT_W-1:0]   pop_cnt;
  logic [PEND_PTR_W-1:0]  pend_head_inc, pend_tail_inc;
  logic [INFL_PTR_W-1:0]  infl_head_inc, infl_tail_inc;

  logic                   pend_we, infl_we;
  logic [TAG_W-1:0]       pend_rdata, infl_rdata, infl_wdata;

  // Unpack the input word
  assign in_action = action_e'(s_axis_tuser);
  assign in_tag    = s_axis_tdata[TAG_W-1:0];
  assign in_amount = s_axis_tdata[TAG_W +: AMT_W];
  assign in_time   = s_axis_tdata[TAG_W+AMT_W +: TIME_W];

  // Handshakes
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Load a new output word this cycle
  assign m_load = (in_fire && (in_action == ACT_PRESENT) && (direct_issue || pend_full)) ||
                  (((state_q == S_DRAIN_EMIT) || (state_q == S_POP_EMIT) ||
                    (state_q == S_UNDER)) && out_free);

  // Issue conditions
  assign can_issue    = (credit_q != '0) &&
                        (infl_fill_q != INFL_FILL_W'(INFLIGHT_DEPTH));
  assign direct_issue = (pend_fill_q == '0) && can_issue;
  assign pend_full    = (pend_fill_q == PEND_FILL_W'(PENDING_DEPTH));

  // Saturating credit add
  assign credit_sum = {1'b0, credit_q} + (CREDIT_W + 1)'(in_amount);
  assign credit_sat = credit_sum[CREDIT_W] ? CREDIT_MAX : credit_sum[CREDIT_W-1:0];

  // Drain: go on now, and whether another issue follows this one
  assign drain_go   = (res_cnt_q < RES_CNT_W'(MAX_RESULTS)) && (pend_fill_q != '0) &&
                      can_issue;
  assign drain_more = ((res_cnt_q + RES_CNT_W'(1)) < RES_CNT_W'(MAX_RESULTS)) &&
                      (pend_fill_q > PEND_FILL_W'(1)) &&
                      (credit_q > CREDIT_W'(1)) &&
                      ((infl_fill_q + INFL_FILL_W'(1)) < INFL_FILL_W'(INFLIGHT_DEPTH));

  // Completion count: clip to the fill, then to the result limit
  assign amt_x     = CMP_W'(in_amount);
  assign fill_x    = CMP_W'(infl_fill_q);
  assign pop_under = amt_x > fill_x;
  assign pop_min   = pop_under ? fill_x : amt_x;
  assign pop_cap   = pop_under ? CMP_W'(MAX_RESULTS - 1) : CMP_W'(MAX_RESULTS);
  assign pop_cnt   = (pop_min > pop_cap) ? RES_CNT_W'(pop_cap) : RES_CNT_W'(pop_min);

  // Wrapping pointer increments
  assign pend_head_inc = (pend_head_q == PEND_PTR_W'(PENDING_DEPTH - 1)) ? '0 :
                         pend_head_q + PEND_PTR_W'(1);
  assign pend_tail_inc = (pend_tail_q == PEND_PTR_W'(PENDING_DEPTH - 1)) ? '0 :
                         pend_tail_q + PEND_PTR_W'(1);
  assign infl_head_inc = (infl_head_q == INFL_PTR_W'(INFLIGHT_DEPTH - 1)) ? '0 :
                         infl_head_q + INFL_PTR_W'(1);
  assign infl_tail_inc = (infl_tail_q == INFL_PTR_W'(INFLIGHT_DEPTH - 1)) ? '0 :
                         infl_tail_q + INFL_PTR_W'(1);

  // Memory write controls; reads always follow the head pointers
  always_comb begin
    pend_we    = in_fire && (in_action == ACT_PRESENT) && !direct_issue && !pend_full;
    infl_we    = (in_fire && (in_action == ACT_PRESENT) && direct_issue) ||
                 ((state_q == S_DRAIN_EMIT) && out_free);
    infl_wdata = (state_q == S_DRAIN_EMIT) ? pend_rdata : in_tag;
  end

  cgpq_ram #(
    .DEPTH (PENDING_DEPTH),
    .WIDTH (TAG_W)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_tail_q),
    .wdata_i (in_tag),
    .raddr_i (pend_head_q),
    .rdata_o (pend_rdata)
  );

  cgpq_ram #(
    .DEPTH (INFLIGHT_DEPTH),
    .WIDTH (TAG_W)
  ) u_infl_ram (
    .clk_i   (clk_i),
    .we_i    (infl_we),
    .waddr_i (infl_tail_q),
    .wdata_i (infl_wdata),
    .raddr_i (infl_head_q),
    .rdata_o (infl_rdata)
  );

  // Sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      credit_q    <= '0;
      pend_head_q <= '0;
      pend_tail_q <= '0;
      pend_fill_q <= '0;
      infl_head_q <= '0;
      infl_tail_q <= '0;
      infl_fill_q <= '0;
      res_cnt_q   <= '0;
      pops_q      <= '0;
      under_q     <= 1'b0;
      time_q      <= '0;
      m_valid_q   <= 1'b0;
      m_kind_q    <= KIND_ISSUED;
      m_tag_q     <= '0;
      m_time_q    <= '0;
      m_last_q    <= 1'b0;
    end else begin
      // Drop the output word once taken, unless a new one replaces it
      if (m_valid_q && m_axis_tready && !m_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_action)
              ACT_PRESENT: begin
                if (direct_issue) begin
                  credit_q    <= credit_q - CREDIT_W'(1);
                  infl_tail_q <= infl_tail_inc;
                  infl_fill_q <= infl_fill_q + INFL_FILL_W'(1);
                  m_valid_q   <= 1'b1;
                  m_kind_q    <= KIND_ISSUED;
                  m_tag_q     <= in_tag;
                  m_time_q    <= '0;
                  m_last_q    <= 1'b1;
                end else if (!pend_full) begin
                  pend_tail_q <= pend_tail_inc;
                  pend_fill_q <= pend_fill_q + PEND_FILL_W'(1);
                end else begin
                  m_valid_q <= 1'b1;
                  m_kind_q  <= KIND_DROP;
                  m_tag_q   <= in_tag;
                  m_time_q  <= '0;
                  m_last_q  <= 1'b1;
                end
              end
              ACT_GRANT: begin
                credit_q  <= credit_sat;
                res_cnt_q <= '0;
                state_q   <= S_DRAIN_CHK;
              end
              ACT_DONE: begin
                pops_q  <= pop_cnt;
                under_q <= pop_under;
                time_q  <= in_time;
                state_q <= S_POP_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_DRAIN_CHK: begin
          state_q <= drain_go ? S_DRAIN_EMIT : S_IDLE;
        end
        S_DRAIN_EMIT: begin
          // Move the pending head into flight
          if (out_free) begin
            pend_head_q <= pend_head_inc;
            pend_fill_q <= pend_fill_q - PEND_FILL_W'(1);
            credit_q    <= credit_q - CREDIT_W'(1);
            infl_tail_q <= infl_tail_inc;
            infl_fill_q <= infl_fill_q + INFL_FILL_W'(1);
            res_cnt_q   <= res_cnt_q + RES_CNT_W'(1);
            m_valid_q   <= 1'b1;
            m_kind_q    <= KIND_ISSUED;
            m_tag_q     <= pend_rdata;
            m_time_q    <= '0;
            m_last_q    <= !drain_more;
            state_q     <= drain_more ? S_DRAIN_CHK : S_IDLE;
          end
        end
        S_POP_RD: begin
          if (pops_q != '0) begin
            state_q <= S_POP_EMIT;
          end else if (under_q) begin
            state_q <= S_UNDER;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_POP_EMIT: begin
          // Report the in-flight head as completed
          if (out_free) begin
            infl_head_q <= infl_head_inc;
            infl_fill_q <= infl_fill_q - INFL_FILL_W'(1);
            pops_q      <= pops_q - RES_CNT_W'(1);
            m_valid_q   <= 1'b1;
            m_kind_q    <= KIND_COMPLETED;
            m_tag_q     <= infl_rdata;
            m_time_q    <= time_q;
            m_last_q    <= (pops_q == RES_CNT_W'(1)) && !under_q;
            state_q     <= S_POP_RD;
          end
        end
        S_UNDER: begin
          if (out_free) begin
            under_q   <= 1'b0;
            m_valid_q <= 1'b1;
            m_kind_q  <= KIND_UNDER;
            m_tag_q   <= '0;
            m_time_q  <= '0;
            m_last_q  <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Pack the output word
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_time_q, m_tag_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  // Fill counts never pass their depths
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_fill_q <= PEND_FILL_W'(PENDING_DEPTH)) &&
    (infl_fill_q <= INFL_FILL_W'(INFLIGHT_DEPTH)))
    else $error("queue fill count exceeds depth");

  // Each drained issue spends exactly one credit
  a_drain_spend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN_EMIT) && out_free |=> credit_q == $past(credit_q) - CREDIT_W'(1))
    else $error("drain issue did not spend one credit");

  // A completion is only reported from a non-empty in-flight queue
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_EMIT) |-> (infl_fill_q != '0))
    else $error("completion popped from empty in-flight queue");

  // A drained issue never overfills the in-flight queue
  a_drain_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN_EMIT) |-> can_issue && (pend_fill_q != '0))
    else $error("drain issued without credit, room or pending entry");

endmodule

`default_nettype wire

// ===== hw/rtl/cgpq_ram.sv =====
// Single-port-write, registered-read memory used for both tag queues.
`default_nettype none

module cgpq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read of the addressed entry
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
